// File: src/kthrec_pkg.sv
`timescale 1ns / 1ps

package kthrec_pkg;

    // Item operation codes
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Result status codes
    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

endpackage

// File: src/kthrec_cell.sv
`timescale 1ns / 1ps

// One position of the sorted chain. Holds a record and shifts it right
// when a smaller key is inserted in front of it.
module kthrec_cell #(
    parameter int YEAR_BITS = 12,
    parameter int SLOT_W    = 6,
    parameter int INDEX     = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 ins_en,
    input  logic                 clr_en,
    input  logic [YEAR_BITS-1:0] new_enlist,
    input  logic [YEAR_BITS-1:0] new_birth,
    input  logic [SLOT_W-1:0]    new_slot,
    input  logic [YEAR_BITS-1:0] left_enlist,
    input  logic [YEAR_BITS-1:0] left_birth,
    input  logic [SLOT_W-1:0]    left_slot,
    input  logic                 left_gt,
    input  logic                 left_le,
    input  logic [SLOT_W-1:0]    sel_idx,
    output logic                 gt,
    output logic                 le,
    output logic                 hit,
    output logic [YEAR_BITS-1:0] enlist,
    output logic [YEAR_BITS-1:0] birth,
    output logic [SLOT_W-1:0]    slot
);
    import kthrec_pkg::*;

    logic                 valid_reg;
    logic [YEAR_BITS-1:0] enlist_reg;
    logic [YEAR_BITS-1:0] birth_reg;
    logic [SLOT_W-1:0]    slot_reg;

    // Held key sorts after the new one; equal keys stay (insertion order)
    assign gt  = valid_reg && ({enlist_reg, birth_reg} > {new_enlist, new_birth});
    assign le  = valid_reg && !gt;
    assign hit = valid_reg && (sel_idx == SLOT_W'(INDEX));

    assign enlist = enlist_reg;
    assign birth  = birth_reg;
    assign slot   = slot_reg;

    // Clear, keep, take the left neighbor, or take the new record
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (clr_en) begin
            valid_reg <= 1'b0;
        end else if (ins_en && !le) begin
            if (left_gt) begin
                valid_reg  <= 1'b1;
                enlist_reg <= left_enlist;
                birth_reg  <= left_birth;
                slot_reg   <= left_slot;
            end else if (left_le) begin
                valid_reg  <= 1'b1;
                enlist_reg <= new_enlist;
                birth_reg  <= new_birth;
                slot_reg   <= new_slot;
            end
        end
    end

endmodule

// File: src/kth_record_by_compound_key_unit.sv
`timescale 1ns / 1ps

// Channel   Ports                                        Direction
// input     s_valid s_ready s_op s_birth_year            in
//           s_enlist_year s_rank_wanted
// result    m_valid m_ready m_status m_entry_slot ...     out
//
// Each transaction (insert, query, clear) completes on acceptance: the sorted chain
// of cells updates in the cycle the transaction is accepted and the result
// lands in the output register on the same edge. Reset empties the chain
// and count at once. A stalled result holds the output register; a new
// transaction is taken in the same cycle the waiting result is taken.
module kth_record_by_compound_key_unit #(
    parameter int TABLE_DEPTH = 64,
    parameter int YEAR_BITS   = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [kthrec_pkg::OP_W-1:0]   s_op,
    input  logic [YEAR_BITS-1:0]          s_birth_year,
    input  logic [YEAR_BITS-1:0]          s_enlist_year,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0] s_rank_wanted,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [kthrec_pkg::ST_W-1:0]   m_status,
    output logic [$clog2(TABLE_DEPTH)-1:0] m_entry_slot,
    output logic [YEAR_BITS-1:0]          m_entry_birth,
    output logic [YEAR_BITS-1:0]          m_entry_enlist,
    output logic [$clog2(TABLE_DEPTH)-1:0] m_oldest_slot,
    output logic [$clog2(TABLE_DEPTH)-1:0] m_youngest_slot,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] m_entry_count
);
    import kthrec_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    logic                 accept;
    logic                 full;
    logic                 ins_en;
    logic                 clr_en;
    logic                 rank_ok;
    logic [SLOT_W-1:0]    sel_idx;

    logic [CNT_W-1:0]     count_reg, count_next;
    logic [SLOT_W-1:0]    old_slot_reg, old_slot_next;
    logic [YEAR_BITS-1:0] old_birth_reg, old_birth_next;
    logic [SLOT_W-1:0]    young_slot_reg, young_slot_next;
    logic [YEAR_BITS-1:0] young_birth_reg, young_birth_next;

    logic                 m_valid_reg;
    logic [ST_W-1:0]      status_reg, status_next;
    logic [SLOT_W-1:0]    eslot_reg, eslot_next;
    logic [YEAR_BITS-1:0] ebirth_reg, ebirth_next;
    logic [YEAR_BITS-1:0] eenlist_reg, eenlist_next;
    logic [SLOT_W-1:0]    oslot_reg, oslot_next;
    logic [SLOT_W-1:0]    yslot_reg, yslot_next;
    logic [CNT_W-1:0]     ocount_reg;

    // Chain wiring; index 0 is the fixed left boundary
    logic [TABLE_DEPTH:0]                 c_gt;
    logic [TABLE_DEPTH:0]                 c_le;
    logic [TABLE_DEPTH:0][YEAR_BITS-1:0]  c_enlist;
    logic [TABLE_DEPTH:0][YEAR_BITS-1:0]  c_birth;
    logic [TABLE_DEPTH:0][SLOT_W-1:0]     c_slot;
    logic [TABLE_DEPTH-1:0]               c_hit;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(TABLE_DEPTH));
    assign ins_en  = accept && (s_op == OP_INSERT) && !full;
    assign clr_en  = accept && (s_op == OP_CLEAR);
    assign rank_ok = (s_rank_wanted != '0) && (s_rank_wanted <= count_reg);
    assign sel_idx = SLOT_W'(s_rank_wanted - CNT_W'(1));

    assign c_gt[0]     = 1'b0;
    assign c_le[0]     = 1'b1;
    assign c_enlist[0] = '0;
    assign c_birth[0]  = '0;
    assign c_slot[0]   = '0;

    // Sorted chain of record cells
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        kthrec_cell #(
            .YEAR_BITS (YEAR_BITS),
            .SLOT_W    (SLOT_W),
            .INDEX     (i)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ins_en      (ins_en),
            .clr_en      (clr_en),
            .new_enlist  (s_enlist_year),
            .new_birth   (s_birth_year),
            .new_slot    (count_reg[SLOT_W-1:0]),
            .left_enlist (c_enlist[i]),
            .left_birth  (c_birth[i]),
            .left_slot   (c_slot[i]),
            .left_gt     (c_gt[i]),
            .left_le     (c_le[i]),
            .sel_idx     (sel_idx),
            .gt          (c_gt[i+1]),
            .le          (c_le[i+1]),
            .hit         (c_hit[i]),
            .enlist      (c_enlist[i+1]),
            .birth       (c_birth[i+1]),
            .slot        (c_slot[i+1])
        );
    end

    // Selected record: OR of the one matching cell
    logic [YEAR_BITS-1:0] sel_enlist;
    logic [YEAR_BITS-1:0] sel_birth;
    logic [SLOT_W-1:0]    sel_slot;

    always_comb begin
        sel_enlist = '0;
        sel_birth  = '0;
        sel_slot   = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (c_hit[i]) begin
                sel_enlist = sel_enlist | c_enlist[i+1];
                sel_birth  = sel_birth  | c_birth[i+1];
                sel_slot   = sel_slot   | c_slot[i+1];
            end
        end
    end

    // Table state and result for the accepted transaction
    always_comb begin
        count_next       = count_reg;
        old_slot_next    = old_slot_reg;
        old_birth_next   = old_birth_reg;
        young_slot_next  = young_slot_reg;
        young_birth_next = young_birth_reg;
        status_next      = ST_OK;
        eslot_next       = '0;
        ebirth_next      = '0;
        eenlist_next     = '0;
        case (s_op)
            OP_INSERT: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                    if (count_reg == '0 || s_birth_year <= old_birth_reg) begin
                        old_slot_next  = count_reg[SLOT_W-1:0];
                        old_birth_next = s_birth_year;
                    end
                    if (count_reg == '0 || s_birth_year >= young_birth_reg) begin
                        young_slot_next  = count_reg[SLOT_W-1:0];
                        young_birth_next = s_birth_year;
                    end
                end
            end
            OP_QUERY: begin
                if (rank_ok) begin
                    eslot_next   = sel_slot;
                    ebirth_next  = sel_birth;
                    eenlist_next = sel_enlist;
                end else begin
                    status_next = ST_RANGE;
                end
            end
            OP_CLEAR: begin
                count_next = '0;
            end
            default: begin
            end
        endcase
        oslot_next = (count_next == '0) ? '0 : old_slot_next;
        yslot_next = (count_next == '0) ? '0 : young_slot_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg       <= count_next;
                old_slot_reg    <= old_slot_next;
                old_birth_reg   <= old_birth_next;
                young_slot_reg  <= young_slot_next;
                young_birth_reg <= young_birth_next;
                status_reg      <= status_next;
                eslot_reg       <= eslot_next;
                ebirth_reg      <= ebirth_next;
                eenlist_reg     <= eenlist_next;
                oslot_reg       <= oslot_next;
                yslot_reg       <= yslot_next;
                ocount_reg      <= count_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_entry_slot    = eslot_reg;
    assign m_entry_birth   = ebirth_reg;
    assign m_entry_enlist  = eenlist_reg;
    assign m_oldest_slot   = oslot_reg;
    assign m_youngest_slot = yslot_reg;
    assign m_entry_count   = ocount_reg;

endmodule
